@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

@@ hdl/ssort_pkg.sv @@
// ----------------------------------------------------------------------------
// ssort_pkg
// Types and constants shared by the sequence sorter files.
// ----------------------------------------------------------------------------
package ssort_pkg;

    localparam int DataWidth   = 32;
    localparam int CapacityDef = 64;

    typedef struct packed {
        logic signed [DataWidth-1:0] value;
        logic                        last_item;
    } t_in_beat;

    typedef struct packed {
        logic signed [DataWidth-1:0] sorted_value;
        logic                        last_of_run;
        logic                        overflowed;
    } t_out_beat;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;  // insert the broadcast value
        logic shl;  // shift the chain one place toward cell 0
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_FILL  = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

endpackage

@@ hdl/ssort_cell.sv @@
// ----------------------------------------------------------------------------
// ssort_cell
// One insertion cell: holds a value and a valid bit, takes the broadcast
// value or its left neighbor on insert, its right neighbor on shift.
// ----------------------------------------------------------------------------
module ssort_cell
    import ssort_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cell_ctl                   i_ctl,
    input  logic signed [DataWidth-1:0] i_new_val,
    input  logic                        i_left_gt,
    input  logic signed [DataWidth-1:0] i_left_val,
    input  logic                        i_left_vld,
    input  logic signed [DataWidth-1:0] i_right_val,
    input  logic                        i_right_vld,
    output logic                        o_gt,
    output logic signed [DataWidth-1:0] o_val,
    output logic                        o_vld
);

    logic signed [DataWidth-1:0] r_val, n_val;
    logic                        r_vld, n_vld;

    // An empty cell counts as greater than anything.
    assign o_gt  = !r_vld || (r_val > i_new_val);
    assign o_val = r_val;
    assign o_vld = r_vld;

    always_comb begin
        n_val = r_val;
        n_vld = r_vld;
        if (i_ctl.shl) begin
            n_val = i_right_val;
            n_vld = i_right_vld;
        end else if (i_ctl.ins && o_gt) begin
            if (i_left_gt) begin
                n_val = i_left_val;
                n_vld = i_left_vld;
            end else begin
                n_val = i_new_val;
                n_vld = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

endmodule

@@ hdl/sequence_sorter.sv @@
// ----------------------------------------------------------------------------
// sequence_sorter
// Ascending sort of a run of signed values in a chain of insertion cells.
//
//   channel | direction | payload    | handshake
//   --------+-----------+------------+---------------------------
//   in      | input     | t_in_beat  | i_in_valid / o_in_ready
//   out     | output    | t_out_beat | o_out_valid / i_out_ready
//
// Fill: one beat per cycle; a beat goes into the chain in the cycle it is
// accepted (one compare per cell against the broadcast value) if it fits.
// Drain: after the last_item beat, one result per cycle leaves cell 0 while
// the chain shifts; input is held off until the last result is loaded.
// A beat taken while full is dropped and flags the run as overflowed.
// Reset empties the chain at once; out stalls simply pause the drain.
// ----------------------------------------------------------------------------
module sequence_sorter
    import ssort_pkg::*;
#(
    parameter int CAPACITY = CapacityDef
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data
);

    t_state    r_state, n_state;
    logic      r_ovf, n_ovf;
    logic      r_out_valid, n_out_valid;
    t_out_beat r_out_data, n_out_data;

    t_cell_ctl                   w_ctl;
    logic signed [DataWidth-1:0] w_val [CAPACITY];
    logic                        w_vld [CAPACITY];
    logic                        w_gt  [CAPACITY];

    logic w_in_acc;
    logic w_full;
    logic w_load;
    logic w_final;

    assign o_in_ready = (r_state == ST_FILL);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_full     = w_vld[CAPACITY-1];
    assign w_load     = (r_state == ST_DRAIN) && (!r_out_valid || i_out_ready);
    assign w_final    = !w_vld[1];

    assign w_ctl.ins = w_in_acc && !w_full;
    assign w_ctl.shl = w_load;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                        w_lgt;
        logic signed [DataWidth-1:0] w_lval;
        logic                        w_lvld;
        logic signed [DataWidth-1:0] w_rval;
        logic                        w_rvld;

        if (g == 0) begin : g_head
            assign w_lgt  = 1'b0;
            assign w_lval = '0;
            assign w_lvld = 1'b0;
        end else begin : g_mid_l
            assign w_lgt  = w_gt[g-1];
            assign w_lval = w_val[g-1];
            assign w_lvld = w_vld[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_rval = '0;
            assign w_rvld = 1'b0;
        end else begin : g_mid_r
            assign w_rval = w_val[g+1];
            assign w_rvld = w_vld[g+1];
        end

        ssort_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_new_val   (i_in_data.value),
            .i_left_gt   (w_lgt),
            .i_left_val  (w_lval),
            .i_left_vld  (w_lvld),
            .i_right_val (w_rval),
            .i_right_vld (w_rvld),
            .o_gt        (w_gt[g]),
            .o_val       (w_val[g]),
            .o_vld       (w_vld[g])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_FILL: begin
                if (w_in_acc) begin
                    if (w_full) begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_data.last_item) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (w_load) begin
                    n_out_valid             = 1'b1;
                    n_out_data.sorted_value = w_val[0];
                    n_out_data.last_of_run  = w_final;
                    n_out_data.overflowed   = r_ovf;
                    if (w_final) begin
                        n_ovf   = 1'b0;
                        n_state = ST_FILL;
                    end
                end
            end
            default: begin
                n_state = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ hdl/ssort_checker.sv @@
// ----------------------------------------------------------------------------
// ssort_checker
// Port-level checks on the sequence sorter: drain continuity, ordering,
// input hold-off during drain and output stall hold.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssort_checker
    import ssort_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_beat o_out_data
);

    logic w_out_acc;
    logic w_mid_run;

    assign w_out_acc = o_out_valid && i_out_ready;
    assign w_mid_run = w_out_acc && !o_out_data.last_of_run;

    // drain runs without bubbles once the output is taken
    `ASSERT_NEXT(a_drain_cont, i_clk, i_rst_n, w_mid_run, o_out_valid)

    // results come out in ascending order
    `ASSERT_NEXT(a_ascending, i_clk, i_rst_n, w_mid_run,
        o_out_data.sorted_value >= $past(o_out_data.sorted_value))

    // no new beat is taken while a run is still being emitted
    `ASSERT_NOW(a_in_hold, i_clk, i_rst_n,
        o_out_valid && !o_out_data.last_of_run, !o_in_ready)

    // stalled result holds
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_out_data))

endmodule

bind sequence_sorter ssort_checker u_ssort_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
